// ===== hdl/fixed_partition_first_fit_allocator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed partition first fit allocator.
// Each macro expands to one labelled concurrent assertion, sampled on clk
// and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_PARTITION_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and codes shared by the allocator cells and the top level.
// ----------------------------------------------------------------------------
package fpa_pkg;

    // Width used to compare slot numbers against cell indices and the count.
    localparam int SLOT_CMP_W = 7;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_DEFINE  = 2'd0,
        KIND_ALLOC   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_NO_FIT  = 2'd1,
        STAT_NOT_OCC = 2'd2,
        STAT_RANGE   = 2'd3
    } status_t;

    // Request payload.
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  slot;
        logic [15:0] part_size;
        logic [15:0] part_base;
        logic [7:0]  job_id;
        logic [15:0] job_size;
    } req_t;

    // Result payload.
    typedef struct packed {
        logic        ok;
        status_t     status;
        logic [3:0]  granted_slot;
        logic [15:0] granted_base;
        logic [7:0]  released_job;
        logic        all_busy;
    } rsp_t;

    // Token that travels along the row of cells: the request and the result
    // built up so far.
    typedef struct packed {
        req_t req;
        rsp_t rsp;
    } tok_t;

endpackage

// ===== hdl/fpa_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_cell
// One partition slot: holds size, base, busy bit and owner, acts on the token
// passing through and hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module fpa_cell #(
    parameter int IDX = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [4:0]     piu,
    input  logic           tok_in_valid,
    input  fpa_pkg::tok_t  tok_in,
    output logic           tok_out_valid,
    output fpa_pkg::tok_t  tok_out
);

    localparam logic [fpa_pkg::SLOT_CMP_W-1:0] IDX_W = fpa_pkg::SLOT_CMP_W'(IDX);

    logic [15:0]   size_reg;
    logic [15:0]   base_reg;
    logic [7:0]    owner_reg;
    logic          busy_reg;
    logic          busy_next;
    logic          valid_reg;
    fpa_pkg::tok_t tok_reg;
    fpa_pkg::tok_t tok_next;
    logic          in_use;
    logic          sel;
    logic          wr_define;
    logic          wr_alloc;
    logic          step;

    assign step   = en && tok_in_valid;
    assign in_use = IDX_W < {2'b00, piu};
    assign sel    = {3'b000, tok_in.req.slot} == IDX_W;

    // Action of this slot on the passing request.
    always_comb
    begin
        tok_next  = tok_in;
        busy_next = busy_reg;
        wr_define = 1'b0;
        wr_alloc  = 1'b0;
        case (tok_in.req.kind)
            fpa_pkg::KIND_DEFINE:
            begin
                if (sel)
                begin
                    wr_define = 1'b1;
                    busy_next = 1'b0;
                end
            end
            fpa_pkg::KIND_ALLOC:
            begin
                if (in_use && !busy_reg && !tok_in.rsp.ok &&
                    (size_reg >= tok_in.req.job_size))
                begin
                    wr_alloc                  = 1'b1;
                    busy_next                 = 1'b1;
                    tok_next.rsp.ok           = 1'b1;
                    tok_next.rsp.status       = fpa_pkg::STAT_DONE;
                    tok_next.rsp.granted_slot = IDX_W[3:0];
                    tok_next.rsp.granted_base = base_reg;
                end
            end
            fpa_pkg::KIND_RELEASE:
            begin
                // The entry stage has already screened out-of-range slots.
                if (sel && (tok_in.rsp.status == fpa_pkg::STAT_NOT_OCC) && busy_reg)
                begin
                    busy_next                 = 1'b0;
                    tok_next.rsp.ok           = 1'b1;
                    tok_next.rsp.status       = fpa_pkg::STAT_DONE;
                    tok_next.rsp.released_job = owner_reg;
                end
            end
            default:
            begin
            end
        endcase
        tok_next.rsp.all_busy = tok_in.rsp.all_busy & (!in_use | busy_next);
    end

    // Partition contents; undefined until the slot is defined.
    always_ff @(posedge clk)
    begin
        if (step && wr_define)
        begin
            size_reg <= tok_in.req.part_size;
            base_reg <= tok_in.req.part_base;
        end
        if (step && wr_alloc)
        begin
            owner_reg <= tok_in.req.job_id;
        end
    end

    // Busy bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (step)
        begin
            busy_reg <= busy_next;
        end
    end

    // Token hand-over to the next cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= tok_in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out_valid = valid_reg;
    assign tok_out       = tok_reg;

endmodule

// ===== hdl/fixed_partition_first_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_partition_first_fit_allocator_unit
// Fixed partition table with first-fit allocation, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid / in_ready / in_data and results leave on
//   out_valid / out_ready / out_data; one result per request, in order.
//   cfg_we with cfg_wdata sets the number of partitions in use; write it only
//   while no request is in flight.
//   An accepted request is loaded into an entry register and then walks the
//   row of SLOTS cells, one cell per cycle while the row is not held; each
//   cell applies the request to its own partition. One request is in the
//   row at a time, so a new request is accepted once the previous one has
//   reached the output register, and the request rate is set by the length
//   of the cell row.
//   While a result waits in the output register, the next request may be
//   accepted into the entry register, but the whole row holds until out_ready.
//   Reset clears all busy bits, the partition count and the handshake
//   state; sizes, bases and owners hold no value until defined.
// ----------------------------------------------------------------------------
`include "fixed_partition_first_fit_allocator_unit_macros.svh"

module fixed_partition_first_fit_allocator_unit #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fpa_pkg::req_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fpa_pkg::rsp_t  out_data,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_wdata
);

    localparam logic [fpa_pkg::SLOT_CMP_W-1:0] SLOTS_W = fpa_pkg::SLOT_CMP_W'(SLOTS);

    logic [4:0]    piu_reg;
    logic          entry_valid_reg;
    fpa_pkg::tok_t entry_tok_reg;
    fpa_pkg::tok_t entry_tok_next;
    logic [SLOTS:0] v_chain;
    fpa_pkg::tok_t  tok_chain [0:SLOTS];
    logic          en;
    logic          accept;
    logic          define_in_range;
    logic          release_in_range;
    logic [fpa_pkg::SLOT_CMP_W-1:0] slot_w;

    // Partition count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piu_reg <= 5'd0;
        end
        else if (cfg_we)
        begin
            piu_reg <= cfg_wdata;
        end
    end

    // The row advances unless a result is held at the output.
    assign en        = !v_chain[SLOTS] || out_ready;
    assign in_ready  = !(|v_chain[SLOTS-1:0]);
    assign accept    = in_valid && in_ready;
    assign out_valid = v_chain[SLOTS];
    assign out_data  = tok_chain[SLOTS].rsp;

    // Range checks and the starting result for each kind of request.
    assign slot_w           = {3'b000, in_data.slot};
    assign define_in_range  = slot_w < SLOTS_W;
    assign release_in_range = (slot_w < SLOTS_W) && (slot_w < {2'b00, piu_reg});

    always_comb
    begin
        entry_tok_next                  = '0;
        entry_tok_next.req              = in_data;
        entry_tok_next.rsp.ok           = 1'b0;
        entry_tok_next.rsp.status       = fpa_pkg::STAT_DONE;
        entry_tok_next.rsp.granted_slot = 4'd0;
        entry_tok_next.rsp.granted_base = 16'd0;
        entry_tok_next.rsp.released_job = 8'd0;
        entry_tok_next.rsp.all_busy     = 1'b1;
        case (in_data.kind)
            fpa_pkg::KIND_DEFINE:
            begin
                entry_tok_next.rsp.granted_slot = in_data.slot;
                entry_tok_next.rsp.ok           = define_in_range;
                entry_tok_next.rsp.status       = define_in_range ? fpa_pkg::STAT_DONE
                                                                  : fpa_pkg::STAT_RANGE;
            end
            fpa_pkg::KIND_ALLOC:
            begin
                entry_tok_next.rsp.status = fpa_pkg::STAT_NO_FIT;
            end
            fpa_pkg::KIND_RELEASE:
            begin
                entry_tok_next.rsp.granted_slot = in_data.slot;
                entry_tok_next.rsp.status       = release_in_range ? fpa_pkg::STAT_NOT_OCC
                                                                   : fpa_pkg::STAT_RANGE;
            end
            default:
            begin
            end
        endcase
    end

    // Entry register in front of the first cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            entry_valid_reg <= 1'b1;
        end
        else if (en)
        begin
            entry_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_tok_reg <= entry_tok_next;
        end
    end

    assign v_chain[0]   = entry_valid_reg;
    assign tok_chain[0] = entry_tok_reg;

    // Row of partition cells.
    for (genvar gi = 0; gi < SLOTS; gi++)
    begin : g_cell
        fpa_cell #(
            .IDX (gi)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .en            (en),
            .piu           (piu_reg),
            .tok_in_valid  (v_chain[gi]),
            .tok_in        (tok_chain[gi]),
            .tok_out_valid (v_chain[gi+1]),
            .tok_out       (tok_chain[gi+1])
        );
    end

    // Checks.
    `FPA_ASSERT_SAME(a_single_token, 1'b1, $onehot0(v_chain[SLOTS-1:0]), "more than one request in the cell row")
    `FPA_ASSERT_NEXT(a_accept_loads, accept, entry_valid_reg, "accepted request not loaded")
    `FPA_ASSERT_SAME(a_ok_done, out_valid && out_data.ok, out_data.status == fpa_pkg::STAT_DONE, "ok result with error status")

endmodule

// ===== dv/allocator_result_monitor.sv =====
// ----------------------------------------------------------------------------
// allocator_result_monitor
// Watches the request, result and configuration ports of the partition
// allocator. It keeps its own copy of the partition table, works out the
// result of every accepted request, and compares each accepted result field
// by field with the oldest result still awaited.
// ----------------------------------------------------------------------------
module allocator_result_monitor #(
    parameter int SLOTS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  fpa_pkg::req_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  fpa_pkg::rsp_t  out_data,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_wdata,
    output int             mismatches,
    output int             pending
);
    import fpa_pkg::*;

    // Own copy of the partition table and the partition count.
    logic [15:0] part_size_tbl [SLOTS];
    logic [15:0] part_base_tbl [SLOTS];
    logic [7:0]  owner_tbl     [SLOTS];
    bit          busy_tbl      [SLOTS];
    logic [4:0]  slot_limit;

    rsp_t awaited_results [$];
    int   fail_count;

    assign mismatches = fail_count;

    // Applies one request to the table copy and returns the result it gives.
    function automatic rsp_t apply_to_table(input req_t r);
        rsp_t res;
        int   n;
        bit   found;
        res   = '0;
        found = 1'b0;
        n     = (int'(slot_limit) > SLOTS) ? SLOTS : int'(slot_limit);
        case (r.kind)
            KIND_DEFINE:
            begin
                res.granted_slot = r.slot;
                if (int'(r.slot) < SLOTS)
                begin
                    part_size_tbl[r.slot] = r.part_size;
                    part_base_tbl[r.slot] = r.part_base;
                    busy_tbl[r.slot]      = 1'b0;
                    res.ok                = 1'b1;
                    res.status            = STAT_DONE;
                end
                else
                begin
                    res.status = STAT_RANGE;
                end
            end
            KIND_ALLOC:
            begin
                // First fit: the lowest free slot in use that is large enough.
                res.status = STAT_NO_FIT;
                for (int i = 0; i < n; i++)
                begin
                    if (!found && !busy_tbl[i] && part_size_tbl[i] >= r.job_size)
                    begin
                        found            = 1'b1;
                        busy_tbl[i]      = 1'b1;
                        owner_tbl[i]     = r.job_id;
                        res.ok           = 1'b1;
                        res.status       = STAT_DONE;
                        res.granted_slot = 4'(i);
                        res.granted_base = part_base_tbl[i];
                    end
                end
            end
            KIND_RELEASE:
            begin
                res.granted_slot = r.slot;
                if (int'(r.slot) >= n)
                begin
                    res.status = STAT_RANGE;
                end
                else if (!busy_tbl[r.slot])
                begin
                    res.status = STAT_NOT_OCC;
                end
                else
                begin
                    busy_tbl[r.slot] = 1'b0;
                    res.released_job = owner_tbl[r.slot];
                    res.ok           = 1'b1;
                    res.status       = STAT_DONE;
                end
            end
            default:
            begin
            end
        endcase
        // An empty table counts as fully busy.
        res.all_busy = 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (!busy_tbl[i])
                res.all_busy = 1'b0;
        end
        return res;
    endfunction

    // Track configuration, predict on each accepted request and check each
    // accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                busy_tbl[i] = 1'b0;
            slot_limit = 5'd0;
            awaited_results.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
                slot_limit = cfg_wdata;
            if (in_valid && in_ready)
                awaited_results.push_back(apply_to_table(in_data));
            if (out_valid && out_ready)
            begin
                got = out_data;
                if (awaited_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result with nothing awaited: ok=%0d status=%0d",
                                 got.ok, got.status);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.ok !== want.ok || got.status !== want.status ||
                        got.granted_slot !== want.granted_slot ||
                        got.granted_base !== want.granted_base ||
                        got.released_job !== want.released_job ||
                        got.all_busy !== want.all_busy)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("result differs: expected ok=%0d status=%0d slot=%0d base=%h job=%h all_busy=%0d",
                                     want.ok, want.status, want.granted_slot,
                                     want.granted_base, want.released_job, want.all_busy);
                            $display("                actual   ok=%0d status=%0d slot=%0d base=%h job=%h all_busy=%0d",
                                     got.ok, got.status, got.granted_slot,
                                     got.granted_base, got.released_job, got.all_busy);
                        end
                        fail_count = fail_count + 1;
                    end
                end
            end
            pending <= awaited_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top level of the partition allocator testbench. It drives a short
// directed sequence and then phases of random define, allocate and release
// requests under several partition counts, with random idle cycles on both
// channels, and reports the verdict from the result monitor.
// ----------------------------------------------------------------------------
module tb;
    import fpa_pkg::*;

    localparam int SLOTS          = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = SLOTS + 8;
    localparam int PHASES         = 10;
    localparam int PHASE_REQUESTS = 120;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    req_t       in_data;
    logic       out_valid;
    logic       out_ready;
    rsp_t       out_data;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    int         mismatches;
    int         pending;

    // Stimulus bookkeeping: which slots have a size, and how many take part.
    logic [SLOTS-1:0] defined_mask = '0;
    int               active_slots = 0;
    bit               no_idle      = 1'b0;
    int               idle_cycles  = 0;

    logic [4:0] count_settings [PHASES] = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd7,
                                           5'd16, 5'd3, 5'd12, 5'd16, 5'd2};

    always #4 clk = ~clk;

    fixed_partition_first_fit_allocator_unit #(
        .SLOTS (SLOTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    allocator_result_monitor #(
        .SLOTS (SLOTS)
    ) monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic req_t make_req(input kind_t k, input logic [3:0] s,
                                      input logic [15:0] psize, input logic [15:0] pbase,
                                      input logic [7:0] job, input logic [15:0] jsize);
        req_t r;
        r.kind      = k;
        r.slot      = s;
        r.part_size = psize;
        r.part_base = pbase;
        r.job_id    = job;
        r.job_size  = jsize;
        return r;
    endfunction

    // Sizes lean towards the extremes and small values so that fits happen.
    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly allocate and release within the slots in use. An allocate that
    // could look at a slot with no size yet becomes a define of that slot.
    function automatic req_t random_request();
        req_t             r;
        int               pick;
        logic [SLOTS-1:0] use_mask;
        r = make_req(KIND_DEFINE, 4'($urandom_range(0, 15)), pick_size(),
                     16'($urandom), 8'($urandom), pick_size());
        pick = $urandom_range(0, 99);
        if (pick < 18)
            r.kind = KIND_DEFINE;
        else if (pick < 60)
            r.kind = KIND_ALLOC;
        else if (pick < 95)
        begin
            r.kind = KIND_RELEASE;
            if (active_slots > 0 && $urandom_range(0, 9) != 0)
                r.slot = 4'($urandom_range(0, active_slots - 1));
        end
        else
            r.kind = KIND_NONE;
        use_mask = (active_slots >= SLOTS) ? '1 : SLOTS'((1 << active_slots) - 1);
        if (r.kind == KIND_ALLOC && (defined_mask & use_mask) != use_mask)
        begin
            r.kind = KIND_DEFINE;
            for (int i = SLOTS - 1; i >= 0; i--)
            begin
                if (use_mask[i] && !defined_mask[i])
                    r.slot = 4'(i);
            end
        end
        return r;
    endfunction

    // Offers one request after a random gap and waits for it to be taken.
    task automatic send_request(input req_t r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (r.kind == KIND_DEFINE)
            defined_mask[r.slot] = 1'b1;
        in_data  <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Holds off the sender until every awaited result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_slot_count(input logic [4:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        active_slots = (int'(value) > SLOTS) ? SLOTS : int'(value);
    endtask

    // Result side: a random stall before each result is taken.
    initial
    begin
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 13);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog on cycles in which neither channel moves a request or result.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Main stimulus sequence and verdict.
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 5'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: no fit, release out of range, unused kind.
        send_request(make_req(KIND_ALLOC, 4'd0, 16'h0000, 16'h0000, 8'h01, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_NONE, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF));
        // Define slots outside the count, with extreme sizes and bases.
        send_request(make_req(KIND_DEFINE, 4'hF, 16'hFFFF, 16'hFFFF, 8'h00, 16'h0000));
        send_request(make_req(KIND_DEFINE, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_DEFINE, 4'h1, 16'h0100, 16'h1234, 8'h00, 16'h0000));

        // Two slots: fill the table, miss, release and release again.
        set_slot_count(5'd2);
        send_request(make_req(KIND_ALLOC, 4'h0, 16'h0000, 16'h0000, 8'hFF, 16'h0000));
        send_request(make_req(KIND_ALLOC, 4'h0, 16'h0000, 16'h0000, 8'h11, 16'h0101));
        send_request(make_req(KIND_ALLOC, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0100));
        send_request(make_req(KIND_ALLOC, 4'h0, 16'h0000, 16'h0000, 8'h22, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'h1, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'h1, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'h2, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        // Redefining a busy slot frees it.
        send_request(make_req(KIND_DEFINE, 4'h0, 16'hFFFF, 16'hABCD, 8'h00, 16'h0000));
        send_request(make_req(KIND_ALLOC, 4'h0, 16'h0000, 16'h0000, 8'h5A, 16'hFFFF));
        send_request(make_req(KIND_DEFINE, 4'h0, 16'h0010, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_NONE, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000));

        // A count above the table size counts as the whole table.
        set_slot_count(5'd31);
        send_request(make_req(KIND_RELEASE, 4'hF, 16'h0000, 16'h0000, 8'h00, 16'h0000));
        send_request(make_req(KIND_RELEASE, 4'h0, 16'h0000, 16'h0000, 8'h00, 16'h0000));

        // Random phases, each under its own partition count.
        for (int p = 0; p < PHASES; p++)
        begin
            set_slot_count((p == 8) ? 5'($urandom_range(0, 31)) : count_settings[p]);
            for (int k = 0; k < PHASE_REQUESTS; k++)
            begin
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_request(random_request());
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
